// ===== hdl/pps_pkg.sv =====
// shared constants, token and result types for the prime sieve
`timescale 1ns / 1ps

package pps_pkg;

  localparam int NUM_STAGES  = 32;
  localparam int VALUE_WIDTH = 16;
  localparam int CNT_W       = $clog2(NUM_STAGES + 1);
  localparam int BIT_W       = $clog2(VALUE_WIDTH);

  // one candidate bit travelling down the chain
  typedef struct packed {
    logic act;
    logic dbit;
    logic first;
    logic last;
    logic hit;
  } token_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   done;
    logic                   ovf;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT,
    ST_EMIT
  } state_e;

endpackage

// ===== hdl/pipelined_prime_sieve_unit.sv =====
// top level of the prime sieve: sequencer, chain and output register
//
// channel   dir  tdata                 tuser
// s_axis    in   [15:0] candidate      [0] end_of_run
// m_axis    out  [15:0] prime_value    [0] run_done, [1] table_overflow
//
// a candidate enters msb first, one bit per cycle
// each cell reduces the bit stream modulo its prime; the verdict comes out of the chain's tail
// one candidate at a time: s_axis is ready only in the idle state
// end of run passes through the emit state, which waits for the output slot; candidates below two give no result
// the output register holds a result while m_axis stalls; reset empties the table
`timescale 1ns / 1ps

module pipelined_prime_sieve_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // candidate
  input  logic [0:0]  s_axis_tuser_i,   // end_of_run
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // prime_value
  output logic [1:0]  m_axis_tuser_o    // run_done, table_overflow
);
  import pps_pkg::*;

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] cand_q, cand_in;
  logic [BIT_W-1:0]       bit_q;
  logic [CNT_W-1:0]       used_q;
  result_t                res_q, out_q;
  logic                   out_valid_q;
  token_t                 head, tail;
  logic                   s_xfer, slot_free, verdict, store, load_out, full;

  assign cand_in   = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign s_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign verdict   = tail.act && tail.last;
  assign full      = used_q == CNT_W'(NUM_STAGES);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          if (s_axis_tuser_i[0]) begin
            state_d = ST_EMIT;
          end else if (cand_in >= VALUE_WIDTH'(2)) begin
            state_d = ST_FEED;
          end
        end
      end
      ST_FEED: begin
        if (bit_q == '0) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (verdict) begin
          state_d = tail.hit ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    head            = '0;
    store           = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_FEED: begin
        head.act   = 1'b1;
        head.dbit  = cand_q[bit_q];
        head.first = bit_q == BIT_W'(VALUE_WIDTH - 1);
        head.last  = bit_q == '0;
      end
      ST_WAIT: store = verdict && !tail.hit && !full;
      ST_EMIT: load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_xfer && s_axis_tuser_i[0]) begin
        used_q <= '0;
      end else if (store) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      cand_q <= cand_in;
      bit_q  <= BIT_W'(VALUE_WIDTH - 1);
    end else if (state_q == ST_FEED) begin
      bit_q <= bit_q - BIT_W'(1);
    end
    if (s_xfer && s_axis_tuser_i[0]) begin
      res_q <= '{value: '0, done: 1'b1, ovf: 1'b0};
    end else if (state_q == ST_WAIT && verdict) begin
      res_q <= '{value: cand_q, done: 1'b0, ovf: full};
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  pps_chain u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .tail_o       (tail),
    .used_i       (used_q),
    .store_i      (store),
    .store_data_i (cand_q)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = 16'(out_q.value);
  assign m_axis_tuser_o  = {out_q.ovf, out_q.done};

  a_store_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store |-> used_q < CNT_W'(NUM_STAGES))
    else $error("store into a full table");

  a_verdict_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict |-> state_q == ST_WAIT)
    else $error("chain verdict outside wait state");

  a_eor_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && s_axis_tuser_i[0]) |=> used_q == '0)
    else $error("end of run did not clear the table");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwrote a pending transfer");

endmodule

// ===== hdl/pps_cell.sv =====
// one sieve cell: stored prime and bit-serial remainder against it
`timescale 1ns / 1ps

module pps_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pps_pkg::token_t                tok_i,
  output pps_pkg::token_t                tok_o,
  input  logic                           valid_i,
  input  logic                           wr_en_i,
  input  logic [pps_pkg::VALUE_WIDTH-1:0] wr_data_i
);
  import pps_pkg::*;

  logic [VALUE_WIDTH-1:0] prime_q;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH:0]   shifted;
  token_t                 tok_q, tok_d;

  always_comb begin
    shifted = {(tok_i.first ? '0 : rem_q), tok_i.dbit};
    if (shifted >= {1'b0, prime_q}) begin
      shifted = shifted - {1'b0, prime_q};
    end
    rem_d = shifted[VALUE_WIDTH-1:0];
  end

  always_comb begin
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | (tok_i.act & tok_i.last & valid_i & (rem_d == '0));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prime_q <= wr_data_i;
    end
    if (tok_i.act) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/pps_chain.sv =====
// row of sieve cells with per-cell write and valid decode
`timescale 1ns / 1ps

module pps_chain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pps_pkg::token_t                 head_i,
  output pps_pkg::token_t                 tail_o,
  input  logic [pps_pkg::CNT_W-1:0]       used_i,
  input  logic                            store_i,
  input  logic [pps_pkg::VALUE_WIDTH-1:0] store_data_i
);
  import pps_pkg::*;

  token_t tok [NUM_STAGES+1];

  assign tok[0] = head_i;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
    logic valid;
    logic wr_en;

    assign valid = CNT_W'(i) < used_i;
    assign wr_en = store_i && (used_i == CNT_W'(i));

    pps_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .valid_i   (valid),
      .wr_en_i   (wr_en),
      .wr_data_i (store_data_i)
    );
  end

  assign tail_o = tok[NUM_STAGES];

endmodule

// ===== sim/tb_top.sv =====
// testbench for the prime sieve: directed table, random sieve runs, predicted results
`timescale 1ns / 1ps

module tb_top;
  import pps_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int SETTLE_CYCLES  = 2 * (VALUE_WIDTH + NUM_STAGES + 2);
  localparam int TIMEOUT_CYCLES = 800_000;

  typedef enum logic [2:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_PRIME,
    ROW_DONE
  } row_kind_e;

  typedef struct {
    logic [15:0] cand;
    logic        eor;
    row_kind_e   kind;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // candidate
  logic [0:0]  s_axis_tuser_i;   // end_of_run
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // prime_value
  logic [1:0]  m_axis_tuser_o;   // run_done, table_overflow

  pipelined_prime_sieve_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // sieve state as seen from outside
  logic [VALUE_WIDTH-1:0] sieve_primes [NUM_STAGES];
  int                     primes_held;

  result_t   awaited_results [$];
  stim_row_t directed_rows [$];
  int        mismatch_count;
  int        items_sent;
  int        send_calm;
  int        recv_calm;

  function automatic bit sieve_predict(input logic [15:0] cand, input logic eor,
                                       output result_t res);
    logic [VALUE_WIDTH-1:0] val;
    res = '0;
    val = cand[VALUE_WIDTH-1:0];
    if (eor) begin
      primes_held = 0;
      res.done = 1'b1;
      return 1'b1;
    end
    if (val < 2) return 1'b0;
    for (int i = 0; i < primes_held; i++) begin
      if (val % sieve_primes[i] == 0) return 1'b0;
    end
    res.value = val;
    if (primes_held >= NUM_STAGES) begin
      res.ovf = 1'b1;
      return 1'b1;
    end
    sieve_primes[primes_held] = val;
    primes_held++;
    return 1'b1;
  endfunction

  // wait draw with occasional stretches of back-to-back transfers
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  task automatic add_row(input logic [15:0] cand, input logic eor, input row_kind_e kind);
    stim_row_t row;
    row.cand = cand;
    row.eor  = eor;
    row.kind = kind;
    directed_rows.push_back(row);
  endtask

  // called just after a falling edge; returns just after a falling edge, tvalid still high
  task automatic send_item(input logic [15:0] cand, input logic eor,
                           input row_kind_e kind = ROW_PREDICT);
    int      gap;
    bit      has_res;
    result_t res;
    result_t typed;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i   <= 1'b1;
    s_axis_tdata_i    <= cand;
    s_axis_tuser_i[0] <= eor;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    has_res = sieve_predict(cand, eor, res);
    typed = '0;
    case (kind)
      ROW_PREDICT: begin
        if (has_res) awaited_results.push_back(res);
      end
      ROW_NONE: begin
      end
      ROW_PRIME: begin
        typed.value = cand;
        awaited_results.push_back(typed);
      end
      ROW_DONE: begin
        typed.done = 1'b1;
        awaited_results.push_back(typed);
      end
      default: begin
      end
    endcase
    if (eor || cand >= 2) items_sent++;
    @(negedge clk_i);
  endtask

  // hold the sender until every awaited result has been seen
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  // receiving side
  initial begin
    int      stall;
    result_t want;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      if (awaited_results.size() == 0) begin
        $error("unexpected transfer: prime_value %0d, run_done %0b, table_overflow %0b",
               m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tuser_o[1]);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata_o !== want.value) begin
          $error("prime_value: expected %0d, got %0d", want.value, m_axis_tdata_o);
          mismatch_count++;
        end
        if (m_axis_tuser_o[0] !== want.done) begin
          $error("run_done: expected %0b, got %0b", want.done, m_axis_tuser_o[0]);
          mismatch_count++;
        end
        if (m_axis_tuser_o[1] !== want.ovf) begin
          $error("table_overflow: expected %0b, got %0b", want.ovf, m_axis_tuser_o[1]);
          mismatch_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  // sending side and end of run
  initial begin
    int top;
    int c;
    int n;
    bit first_run;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    primes_held     = 0;
    mismatch_count  = 0;
    items_sent      = 0;
    send_calm       = 0;
    recv_calm       = 0;

    // values below two, first primes, repeats, extremes and clears
    add_row(16'd0,    1'b0, ROW_NONE);
    add_row(16'd1,    1'b0, ROW_NONE);
    add_row(16'd2,    1'b0, ROW_PRIME);
    add_row(16'd3,    1'b0, ROW_PRIME);
    add_row(16'd4,    1'b0, ROW_NONE);
    add_row(16'd5,    1'b0, ROW_PREDICT);
    add_row(16'd6,    1'b0, ROW_PREDICT);
    add_row(16'd7,    1'b0, ROW_PREDICT);
    add_row(16'd2,    1'b0, ROW_PREDICT);
    add_row(16'hFFFF, 1'b0, ROW_PREDICT);
    add_row(16'h0001, 1'b0, ROW_PREDICT);
    add_row(16'hFFFF, 1'b1, ROW_DONE);
    add_row(16'hFFFF, 1'b0, ROW_PRIME);
    add_row(16'h8000, 1'b0, ROW_PREDICT);
    add_row(16'd0,    1'b0, ROW_NONE);
    add_row(16'h0000, 1'b1, ROW_DONE);
    add_row(16'hAAAA, 1'b0, ROW_PRIME);
    add_row(16'h5555, 1'b0, ROW_PREDICT);
    add_row(16'h5555, 1'b1, ROW_DONE);
    add_row(16'd2,    1'b0, ROW_PRIME);
    add_row(16'd9,    1'b0, ROW_PREDICT);
    add_row(16'hAAAA, 1'b1, ROW_DONE);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cand, directed_rows[i].eor, directed_rows[i].kind);
    end
    drain_results();

    items_sent = 0;
    first_run  = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      if (first_run || $urandom_range(0, 99) < 80) begin
        // ascending run from two; long ones fill the table and overflow
        if (first_run) top = 200;
        else if ($urandom_range(0, 9) < 3) top = $urandom_range(140, 220);
        else top = $urandom_range(3, 60);
        c = 2;
        while (c <= top) begin
          send_item(16'(c), 1'b0);
          c += ($urandom_range(0, 9) == 0) ? 2 : 1;
        end
        if ($urandom_range(0, 9) != 0) send_item(16'($urandom_range(0, 65535)), 1'b1);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 3);
          else c = $urandom_range(0, 65535);
          send_item(16'(c), ($urandom_range(0, 7) == 0));
        end
      end
      if ($urandom_range(0, 19) == 0) drain_results();
      first_run = 1'b0;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("pipelined_prime_sieve_unit test passed");
    end else begin
      $display("pipelined_prime_sieve_unit test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("pipelined_prime_sieve_unit test failed");
    $finish;
  end

endmodule
